FILE: hw/rtl/hpe_pkg.sv
// Shared types and constants for the histogram percentile estimator.
// Used by every module of the block; depends on nothing.
package hpe_pkg;

  localparam int NUM_BINS  = 128;
  localparam int BIN_AW    = $clog2(NUM_BINS);
  localparam int MIN_BINS  = 11;
  localparam int NB_W      = 8;
  localparam int CNT_W     = 32;
  localparam int PCT_W     = 14;
  localparam int PCT_FULL  = 10000;
  localparam int CS_W      = 46;   // count * 10000
  localparam int RUN_W     = 54;   // running scaled count
  localparam int NUM_W     = 54;   // interpolation numerator
  localparam int NUM_HALF  = 27;
  localparam int PP_W      = 59;   // 32 x 27 partial product
  localparam int DVD_W     = 86;
  localparam int DVS_W     = 54;
  localparam int Q_W       = 33;
  localparam int DCNT_W    = $clog2(Q_W + 1);

  localparam logic [1:0] CFG_LOWER  = 2'd0;
  localparam logic [1:0] CFG_UPPER  = 2'd1;
  localparam logic [1:0] CFG_MARGIN = 2'd2;
  localparam logic [1:0] CFG_BINS   = 2'd3;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_IGNORED = 2'd1,
    STS_EMPTY   = 2'd2,
    STS_EQUAL   = 2'd3
  } sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_CHK,
    ST_ADD_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_SET,
    ST_Q_RD,
    ST_Q_MUL,
    ST_Q_ACC,
    ST_Q_NUM,
    ST_Q_SUB,
    ST_Q_M0,
    ST_Q_M1,
    ST_Q_M2
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: hw/rtl/hpe_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on hpe_pkg. Caller guarantees the quotient fits Q_W bits.
module hpe_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hpe_pkg::div_req_t     req,
  output logic                  done,
  output logic [hpe_pkg::Q_W-1:0] quot
);

  logic [hpe_pkg::DVS_W-1:0]  rem_r, dvs_r;
  logic [hpe_pkg::Q_W-1:0]    qb_r;
  logic [hpe_pkg::DCNT_W-1:0] cnt_r;
  logic                       done_r;
  logic [hpe_pkg::DVS_W:0]    sh;
  logic                       ge;

  assign sh   = {rem_r, qb_r[hpe_pkg::Q_W-1]};
  assign ge   = sh >= {1'b0, dvs_r};
  assign done = done_r;
  assign quot = qb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= hpe_pkg::DCNT_W'(hpe_pkg::Q_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hpe_pkg::DCNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= hpe_pkg::DVS_W'(req.dividend[hpe_pkg::DVD_W-1:hpe_pkg::Q_W]);
      qb_r  <= req.dividend[hpe_pkg::Q_W-1:0];
      dvs_r <= req.divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? hpe_pkg::DVS_W'(sh - {1'b0, dvs_r}) : hpe_pkg::DVS_W'(sh);
      qb_r  <= {qb_r[hpe_pkg::Q_W-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/hpe_bin_mem.sv
// Bin count store: one-port-write, one-port-read memory with registered read.
// Depends on hpe_pkg. Per-entry valid bits make cleared entries read as zero.
module hpe_bin_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic [hpe_pkg::BIN_AW-1:0] rd_addr,
  input  logic                       wr_en,
  input  logic [hpe_pkg::BIN_AW-1:0] wr_addr,
  input  logic [hpe_pkg::CNT_W-1:0]  wr_data,
  output logic [hpe_pkg::CNT_W-1:0]  rd_data
);

  logic [hpe_pkg::CNT_W-1:0]  mem [hpe_pkg::NUM_BINS];
  logic [hpe_pkg::NUM_BINS-1:0] vld_r;
  logic [hpe_pkg::CNT_W-1:0]  q_r;
  logic                       qv_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r  <= mem[rd_addr];
    qv_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

FILE: hw/rtl/histogram_percentile_estimator_unit.sv
// Histogram percentile estimator. One word at a time: in_stall is high from
// acceptance until the result is in the output register. An add finds its
// bin with the 33-step shared divider; a query walks the bins with a memory
// read, scale and accumulate step per bin, then interpolates using the same
// divider; clear and the unused command go straight to the output register.
// Counts reset through per-bin valid bits, so no clearing pass.
module histogram_percentile_estimator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_sample,
  input  logic [13:0] in_percent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // configuration
  logic [31:0]             lower_r, upper_r;
  logic [30:0]             margin_r;
  logic [hpe_pkg::NB_W-1:0] bins_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r  <= '0;
      upper_r  <= '0;
      margin_r <= 31'h7FFF_FFFF;
      bins_r   <= 8'd101;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hpe_pkg::CFG_LOWER:  lower_r  <= cfg_wdata;
        hpe_pkg::CFG_UPPER:  upper_r  <= cfg_wdata;
        hpe_pkg::CFG_MARGIN: margin_r <= cfg_wdata[30:0];
        hpe_pkg::CFG_BINS:   bins_r   <= cfg_wdata[7:0];
        default:             lower_r  <= lower_r;
      endcase
    end
  end

  logic [31:0]              lo, hi, width;
  logic [hpe_pkg::NB_W-1:0] nb;

  assign lo    = ($signed(lower_r) < $signed(upper_r)) ? lower_r : upper_r;
  assign hi    = ($signed(lower_r) < $signed(upper_r)) ? upper_r : lower_r;
  assign width = hi - lo;
  assign nb    = (bins_r < hpe_pkg::NB_W'(hpe_pkg::MIN_BINS)) ?
                   hpe_pkg::NB_W'(hpe_pkg::MIN_BINS) :
                 (bins_r > hpe_pkg::NB_W'(hpe_pkg::NUM_BINS)) ?
                   hpe_pkg::NB_W'(hpe_pkg::NUM_BINS) : bins_r;

  // item and working registers
  hpe_pkg::state_t state_r, state_nxt;
  hpe_pkg::cmd_t   cmd_r;
  hpe_pkg::sts_t   res_status_r;
  logic [31:0]     sample_r, res_value_r, off_r;
  logic [hpe_pkg::PCT_W-1:0]  pct_r;
  logic [hpe_pkg::CNT_W-1:0]  total_r;
  logic [hpe_pkg::CS_W-1:0]   target_r, cs_r, last_cs_r, sel_cs_r;
  logic [hpe_pkg::RUN_W-1:0]  run_r, sub_r;
  logic [hpe_pkg::NB_W-1:0]   idx_r, last_i_r, sel_i_r;
  logic                       cnz_r, have_last_r;
  logic [hpe_pkg::BIN_AW-1:0] bin_r;
  logic [hpe_pkg::NUM_W-1:0]  p_r, num_r;
  logic [hpe_pkg::PP_W-1:0]   acc_r, ph_r;
  logic [hpe_pkg::DVD_W-1:0]  dvd_r;
  logic [hpe_pkg::DVS_W-1:0]  dvs_r;
  logic                       out_valid_r;
  logic [31:0]                out_value_r;
  logic [1:0]                 out_status_r;
  logic                       fin_r;

  logic                       accept, load_out;
  logic                       div_done;
  logic [hpe_pkg::Q_W-1:0]    quot;
  hpe_pkg::div_req_t          div_req;
  logic                       mem_clr, mem_we;
  logic [hpe_pkg::BIN_AW-1:0] mem_raddr;
  logic [hpe_pkg::CNT_W-1:0]  mem_rdata, mem_wdata;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != hpe_pkg::ST_IDLE) || fin_r;
  assign load_out = fin_r && (!out_valid_r || !out_stall);

  // add: clamp and range check
  logic signed [33:0] s34, lo34, hi34, dlo, dhi, m34, sc;
  logic               add_eq, add_out;

  assign s34  = 34'(signed'(sample_r));
  assign lo34 = 34'(signed'(lo));
  assign hi34 = 34'(signed'(hi));
  assign m34  = signed'({3'b000, margin_r});
  assign dlo  = lo34 - s34;
  assign dhi  = s34 - hi34;
  always_comb begin
    sc = s34;
    if (s34 < lo34 && dlo < m34) begin
      sc = lo34;
    end
    if (sc > hi34 && dhi < m34) begin
      sc = hi34;
    end
  end
  assign add_eq  = (lo == hi);
  assign add_out = (sc < lo34) || (sc > hi34);

  logic [39:0]                add_prod;
  logic [hpe_pkg::NB_W-1:0]   qbin;
  logic [hpe_pkg::PCT_W-1:0]  pct_c;
  logic [hpe_pkg::CS_W-1:0]   cs_w, target_w;
  logic [hpe_pkg::RUN_W-1:0]  run_sum;
  logic                       hit, last_bin;

  assign add_prod = 40'(off_r) * 40'(nb);
  assign qbin     = (quot[hpe_pkg::NB_W-1:0] > nb - 1'b1) ? nb - 1'b1
                                                          : quot[hpe_pkg::NB_W-1:0];
  assign pct_c    = (pct_r > hpe_pkg::PCT_W'(hpe_pkg::PCT_FULL)) ?
                      hpe_pkg::PCT_W'(hpe_pkg::PCT_FULL) : pct_r;
  assign target_w = hpe_pkg::CS_W'(total_r) * hpe_pkg::CS_W'(pct_c);
  assign cs_w     = hpe_pkg::CS_W'(mem_rdata) * hpe_pkg::CS_W'(hpe_pkg::PCT_FULL);
  assign run_sum  = run_r + hpe_pkg::RUN_W'(cs_r);
  assign hit      = cnz_r && (run_sum >= hpe_pkg::RUN_W'(target_r));
  assign last_bin = (idx_r == nb - 1'b1);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mem_raddr = bin_r;
    mem_we    = 1'b0;
    mem_clr   = 1'b0;
    mem_wdata = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = dvd_r;
    div_req.divisor  = dvs_r;
    unique case (state_r)
      hpe_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (hpe_pkg::cmd_t'(in_command))
            hpe_pkg::CMD_ADD:   state_nxt = hpe_pkg::ST_ADD_CHK;
            hpe_pkg::CMD_QUERY: state_nxt = hpe_pkg::ST_Q_SET;
            hpe_pkg::CMD_CLEAR: mem_clr   = 1'b1;
            default:            state_nxt = hpe_pkg::ST_IDLE;
          endcase
        end
      end
      hpe_pkg::ST_ADD_CHK: begin
        state_nxt = (add_eq || add_out) ? hpe_pkg::ST_IDLE : hpe_pkg::ST_ADD_MUL;
      end
      hpe_pkg::ST_ADD_MUL: state_nxt = hpe_pkg::ST_DIV_GO;
      hpe_pkg::ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_nxt     = hpe_pkg::ST_DIV_WAIT;
      end
      hpe_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (cmd_r == hpe_pkg::CMD_ADD) ? hpe_pkg::ST_ADD_RD : hpe_pkg::ST_IDLE;
        end
      end
      hpe_pkg::ST_ADD_RD: state_nxt = hpe_pkg::ST_ADD_WR;
      hpe_pkg::ST_ADD_WR: begin
        mem_we    = 1'b1;
        state_nxt = hpe_pkg::ST_IDLE;
      end
      hpe_pkg::ST_Q_SET: begin
        state_nxt = (total_r == '0) ? hpe_pkg::ST_IDLE : hpe_pkg::ST_Q_RD;
      end
      hpe_pkg::ST_Q_RD: begin
        mem_raddr = idx_r[hpe_pkg::BIN_AW-1:0];
        state_nxt = hpe_pkg::ST_Q_MUL;
      end
      hpe_pkg::ST_Q_MUL: state_nxt = hpe_pkg::ST_Q_ACC;
      hpe_pkg::ST_Q_ACC: begin
        priority if (hit) begin
          state_nxt = hpe_pkg::ST_Q_NUM;
        end else if (last_bin) begin
          state_nxt = (cnz_r || have_last_r) ? hpe_pkg::ST_Q_NUM : hpe_pkg::ST_IDLE;
        end else begin
          state_nxt = hpe_pkg::ST_Q_RD;
        end
      end
      hpe_pkg::ST_Q_NUM: state_nxt = hpe_pkg::ST_Q_SUB;
      hpe_pkg::ST_Q_SUB: state_nxt = hpe_pkg::ST_Q_M0;
      hpe_pkg::ST_Q_M0:  state_nxt = hpe_pkg::ST_Q_M1;
      hpe_pkg::ST_Q_M1:  state_nxt = hpe_pkg::ST_Q_M2;
      hpe_pkg::ST_Q_M2:  state_nxt = hpe_pkg::ST_DIV_GO;
      default:           state_nxt = hpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // fin_r marks a finished word waiting for the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      if (load_out) begin
        fin_r <= 1'b0;
      end else if (state_r != hpe_pkg::ST_IDLE && state_nxt == hpe_pkg::ST_IDLE) begin
        fin_r <= 1'b1;
      end else if (accept && (in_command == hpe_pkg::CMD_CLEAR ||
                              in_command == hpe_pkg::CMD_NOP)) begin
        fin_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (mem_clr) begin
        total_r <= '0;
      end else if (mem_we && total_r != '1) begin
        total_r <= total_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= hpe_pkg::cmd_t'(in_command);
      sample_r     <= in_sample;
      pct_r        <= in_percent;
      res_value_r  <= '0;
      res_status_r <= hpe_pkg::STS_OK;
    end
    unique case (state_r)
      hpe_pkg::ST_ADD_CHK: begin
        off_r <= 32'(sc - lo34);
        if (add_eq) begin
          res_status_r <= hpe_pkg::STS_EQUAL;
        end else if (add_out) begin
          res_status_r <= hpe_pkg::STS_IGNORED;
        end
      end
      hpe_pkg::ST_ADD_MUL: begin
        dvd_r <= hpe_pkg::DVD_W'(add_prod);
        dvs_r <= hpe_pkg::DVS_W'(width);
      end
      hpe_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          bin_r       <= qbin[hpe_pkg::BIN_AW-1:0];
          if (cmd_r == hpe_pkg::CMD_QUERY) begin
            res_value_r <= lo + quot[31:0];
          end
        end
      end
      hpe_pkg::ST_Q_SET: begin
        target_r    <= target_w;
        idx_r       <= '0;
        run_r       <= '0;
        have_last_r <= 1'b0;
        if (total_r == '0) begin
          res_status_r <= hpe_pkg::STS_EMPTY;
        end
      end
      hpe_pkg::ST_Q_MUL: begin
        cs_r  <= cs_w;
        cnz_r <= (mem_rdata != '0);
      end
      hpe_pkg::ST_Q_ACC: begin
        run_r <= run_sum;
        idx_r <= idx_r + 1'b1;
        if (cnz_r) begin
          last_i_r    <= idx_r;
          last_cs_r   <= cs_r;
          have_last_r <= 1'b1;
        end
        priority if (hit) begin
          sel_i_r  <= idx_r;
          sel_cs_r <= cs_r;
          sub_r    <= run_sum - hpe_pkg::RUN_W'(target_r);
        end else if (cnz_r) begin
          sel_i_r  <= idx_r;
          sel_cs_r <= cs_r;
          sub_r    <= '0;
        end else begin
          // walk exhausted: fall back on the last nonzero bin
          sel_i_r  <= last_i_r;
          sel_cs_r <= last_cs_r;
          sub_r    <= '0;
          if (last_bin && !have_last_r) begin
            res_status_r <= hpe_pkg::STS_EMPTY;
          end
        end
      end
      hpe_pkg::ST_Q_NUM: begin
        p_r   <= hpe_pkg::NUM_W'({1'b0, sel_i_r} + 1'b1) * hpe_pkg::NUM_W'(sel_cs_r);
        dvs_r <= hpe_pkg::DVS_W'(sel_cs_r) * hpe_pkg::DVS_W'(nb);
      end
      hpe_pkg::ST_Q_SUB: num_r <= p_r - hpe_pkg::NUM_W'(sub_r);
      hpe_pkg::ST_Q_M0: begin
        acc_r <= hpe_pkg::PP_W'(width) * hpe_pkg::PP_W'(num_r[hpe_pkg::NUM_HALF-1:0]);
      end
      hpe_pkg::ST_Q_M1: begin
        ph_r <= hpe_pkg::PP_W'(width) *
                hpe_pkg::PP_W'(num_r[hpe_pkg::NUM_W-1:hpe_pkg::NUM_HALF]);
      end
      hpe_pkg::ST_Q_M2: begin
        dvd_r <= hpe_pkg::DVD_W'(acc_r) + (hpe_pkg::DVD_W'(ph_r) << hpe_pkg::NUM_HALF);
      end
      default: begin
      end
    endcase
  end

  hpe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (quot)
  );

  hpe_bin_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (mem_clr),
    .rd_addr (mem_raddr),
    .wr_en   (mem_we),
    .wr_addr (bin_r),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

FILE: hw/rtl/hpe_checker.sv
// Port-level checks for the histogram percentile estimator, bound to the top.
// Depends on the top level's port list and on hpe_pkg for the status codes.
module hpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_value,
  input logic [1:0]  out_status
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result word changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != hpe_pkg::STS_OK |-> out_value == 32'd0)
    else $error("nonzero value with error status");

endmodule

bind histogram_percentile_estimator_unit hpe_checker u_hpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_value  (out_value),
  .out_status (out_status)
);

FILE: tb/sv/hpe_scoreboard.sv
// Scoreboard for the histogram percentile estimator: predicts each result word.
// Depends on hpe_pkg for the command, status and size definitions.
`timescale 1ns / 1ps

class hpe_scoreboard;
  logic [31:0] lower_q, upper_q;
  logic [30:0] margin_q;
  logic [7:0]  bins_q;
  logic [31:0] counts[hpe_pkg::NUM_BINS];
  logic [31:0] total;
  logic [31:0] exp_value[$];
  hpe_pkg::sts_t exp_status[$];
  int mismatches;
  int checked;
  int n_add, n_query, n_clear, n_ok_query;

  function new();
    lower_q = '0;
    upper_q = '0;
    margin_q = 31'h7FFFFFFF;
    bins_q = 8'd101;
    mismatches = 0;
    checked = 0;
    n_add = 0; n_query = 0; n_clear = 0; n_ok_query = 0;
    wipe();
  endfunction

  function void wipe();
    foreach (counts[i]) counts[i] = '0;
    total = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      hpe_pkg::CFG_LOWER:  lower_q = data;
      hpe_pkg::CFG_UPPER:  upper_q = data;
      hpe_pkg::CFG_MARGIN: margin_q = data[30:0];
      default:             bins_q = data[7:0];
    endcase
  endfunction

  // floor(w*num/den), exact in 128 bits
  function automatic logic [63:0] scale_div(logic [63:0] w, logic [63:0] num,
                                            logic [63:0] den);
    logic [127:0] prod;
    prod = {64'd0, w} * {64'd0, num};
    if (den == 0) return '0;
    return 64'(prod / {64'd0, den});
  endfunction

  function void note_input(hpe_pkg::cmd_t cmd, logic [31:0] smp, logic [13:0] pct_in);
    longint lo, hi, s, marg, val;
    longint unsigned width, nb, bin, pct, target, run, c, num, den;
    int found, last;
    hpe_pkg::sts_t st;
    lo = longint'($signed(lower_q));
    hi = longint'($signed(upper_q));
    if (lo > hi) begin
      s = lo; lo = hi; hi = s;
    end
    marg = longint'(margin_q);
    width = longint'(hi - lo);
    nb = bins_q;
    if (nb < hpe_pkg::MIN_BINS) nb = hpe_pkg::MIN_BINS;
    if (nb > hpe_pkg::NUM_BINS) nb = hpe_pkg::NUM_BINS;
    val = 0;
    st = hpe_pkg::STS_OK;
    case (cmd)
      hpe_pkg::CMD_ADD: begin
        n_add++;
        s = longint'($signed(smp));
        if (s < lo && lo - s < marg) s = lo;
        if (s > hi && s - hi < marg) s = hi;
        if (lo == hi) st = hpe_pkg::STS_EQUAL;
        else if (s < lo || s > hi) st = hpe_pkg::STS_IGNORED;
        else begin
          bin = (longint'(s - lo) * nb) / width;
          if (bin > nb - 1) bin = nb - 1;
          if (counts[bin] != 32'hFFFFFFFF) counts[bin]++;
          if (total != 32'hFFFFFFFF) total++;
        end
      end
      hpe_pkg::CMD_QUERY: begin
        n_query++;
        pct = pct_in;
        if (pct > hpe_pkg::PCT_FULL) pct = hpe_pkg::PCT_FULL;
        target = longint'(total) * pct;
        run = 0;
        found = int'(nb);
        last = int'(nb);
        if (total != 0) begin
          for (int i = 0; i < int'(nb); i++) begin
            c = counts[i];
            run += c;
            if (c != 0) begin
              last = i;
              if (run * hpe_pkg::PCT_FULL >= target) begin
                found = i;
                break;
              end
            end
          end
        end
        if (total == 0 || last == int'(nb)) st = hpe_pkg::STS_EMPTY;
        else begin
          if (found != int'(nb)) begin
            c = counts[found];
            num = longint'(found + 1) * c * hpe_pkg::PCT_FULL
                  - run * hpe_pkg::PCT_FULL + target;
          end else begin
            found = last;
            c = counts[found];
            num = longint'(found + 1) * c * hpe_pkg::PCT_FULL;
          end
          den = c * hpe_pkg::PCT_FULL * nb;
          val = lo + longint'(scale_div(width, num, den));
          n_ok_query++;
        end
      end
      hpe_pkg::CMD_CLEAR: begin
        n_clear++;
        wipe();
      end
      default: ;
    endcase
    exp_value.push_back(val[31:0]);
    exp_status.push_back(st);
  endfunction

  function void check_result(logic [31:0] value, logic [1:0] status);
    logic [31:0] ev;
    hpe_pkg::sts_t es;
    checked++;
    if (exp_value.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: value %h status %0d", value, status);
      return;
    end
    ev = exp_value.pop_front();
    es = exp_status.pop_front();
    if (ev !== value || es !== status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on word %0d: exp value %h status %0d, got value %h status %0d",
                 checked, ev, es, value, status);
    end
  endfunction

  function int pending();
    return exp_value.size();
  endfunction
endclass

FILE: tb/sv/testbench.sv
// Top-level testbench for histogram_percentile_estimator_unit: directed and random
// command words, random idling on both sides. Depends on hpe_pkg and hpe_scoreboard.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS = 900;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [31:0] in_sample;
  logic [13:0] in_percent;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_value;
  logic [1:0]  out_status;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  hpe_scoreboard sb;
  int  idle_cycles;
  int  send_gap_pct;
  int  recv_gap_pct;
  bit  hold_off;
  logic [31:0] cur_lo, cur_hi;

  histogram_percentile_estimator_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // scoreboard taps on accepted words
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_input(hpe_pkg::cmd_t'(in_command), in_sample, in_percent);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_value, out_status);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else if (hold_off)
      out_stall <= 1'b1;
    else
      out_stall <= ($urandom_range(99) < recv_gap_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_range(logic [31:0] lo, logic [31:0] hi, logic [30:0] marg,
                           logic [7:0] nb);
    write_reg(hpe_pkg::CFG_LOWER, lo);
    write_reg(hpe_pkg::CFG_UPPER, hi);
    write_reg(hpe_pkg::CFG_MARGIN, {1'b0, marg});
    write_reg(hpe_pkg::CFG_BINS, nb);
    cur_lo = lo;
    cur_hi = hi;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // offer one word; valid stays high across back-to-back words
  task automatic send_word(hpe_pkg::cmd_t cmd, logic [31:0] smp, logic [13:0] pct);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample <= smp;
    in_percent <= pct;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sample near or inside the current range, sometimes anywhere
  function automatic logic [31:0] pick_sample();
    longint lo, hi, span;
    lo = longint'($signed(cur_lo));
    hi = longint'($signed(cur_hi));
    if (lo > hi) begin
      span = lo; lo = hi; hi = span;
    end
    span = hi - lo;
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'(lo - longint'($urandom_range(65536)));
      2: return 32'(hi + longint'($urandom_range(65536)));
      3: return 32'(lo);
      4: return 32'(hi);
      default: return 32'(lo + longint'({$urandom(), $urandom()} % (span + 1)));
    endcase
  endfunction

  task automatic random_phase(int words);
    int r;
    for (int k = 0; k < words; k++) begin
      r = $urandom_range(99);
      if (r < 60) send_word(hpe_pkg::CMD_ADD, pick_sample(), 14'($urandom()));
      else if (r < 90)
        send_word(hpe_pkg::CMD_QUERY, $urandom(),
                  ($urandom_range(9) == 0) ? 14'($urandom()) : 14'($urandom_range(10000)));
      else if (r < 95) send_word(hpe_pkg::CMD_CLEAR, $urandom(), 14'($urandom()));
      else send_word(hpe_pkg::CMD_NOP, $urandom(), 14'($urandom()));
    end
    idle_input();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = hpe_pkg::CMD_ADD;
    in_sample = '0;
    in_percent = '0;
    cfg_wr_en = 1'b0;
    cfg_index = hpe_pkg::CFG_LOWER;
    cfg_wdata = '0;
    send_gap_pct = 24;
    recv_gap_pct = 24;
    hold_off = 1'b0;
    cur_lo = '0;
    cur_hi = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, equal bounds, extremes
    send_word(hpe_pkg::CMD_QUERY, '0, 14'd5000);
    send_word(hpe_pkg::CMD_ADD, 32'h0001_0000, '0);
    send_word(hpe_pkg::CMD_NOP, 32'hFFFF_FFFF, 14'h3FFF);
    idle_input();
    wait_drained();
    set_range(32'h0064_0000, 32'hFF9C_0000, 31'h0001_0000, 8'd0);
    send_word(hpe_pkg::CMD_ADD, 32'h8000_0000, '0);
    send_word(hpe_pkg::CMD_ADD, 32'h7FFF_FFFF, '0);
    send_word(hpe_pkg::CMD_ADD, 32'h0064_8000, '0);
    send_word(hpe_pkg::CMD_ADD, 32'hFF9B_8000, '0);
    send_word(hpe_pkg::CMD_ADD, 32'h0000_0000, '0);
    send_word(hpe_pkg::CMD_ADD, 32'h0064_0000, '0);
    send_word(hpe_pkg::CMD_ADD, 32'hFF9C_0000, '0);
    send_word(hpe_pkg::CMD_QUERY, '0, 14'd0);
    send_word(hpe_pkg::CMD_QUERY, '0, 14'd10000);
    send_word(hpe_pkg::CMD_QUERY, '0, 14'h3FFF);
    send_word(hpe_pkg::CMD_QUERY, '0, 14'd2500);
    send_word(hpe_pkg::CMD_CLEAR, '0, '0);
    send_word(hpe_pkg::CMD_QUERY, '0, 14'd5000);
    idle_input();
    wait_drained();
    set_range(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 8'd255);
    send_word(hpe_pkg::CMD_ADD, 32'h8000_0000, '0);
    send_word(hpe_pkg::CMD_ADD, 32'h7FFF_FFFF, '0);
    send_word(hpe_pkg::CMD_ADD, 32'h1234_5678, '0);
    send_word(hpe_pkg::CMD_QUERY, '0, 14'd5000);
    send_word(hpe_pkg::CMD_QUERY, '0, 14'd1);
    idle_input();
    wait_drained();
    // shrinking bins keeps counts beyond B: walk-exhausted case
    write_reg(hpe_pkg::CFG_BINS, 8'd11);
    send_word(hpe_pkg::CMD_QUERY, '0, 14'd10000);
    idle_input();
    wait_drained();

    // random phases over several settings
    set_range(32'hFFF6_0000, 32'h000A_0000, 31'h0000_8000, 8'd128);
    random_phase(200);
    wait_drained();
    set_range(32'h0000_0000, 32'h0000_0100, 31'h0000_0000, 8'd11);
    random_phase(150);
    wait_drained();
    // no idling here
    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_range($urandom(), $urandom(), 31'($urandom()), 8'($urandom_range(255)));
    random_phase(150);
    wait_drained();
    send_gap_pct = 24;
    recv_gap_pct = 24;
    set_range(32'h7FFF_0000, 32'h7FFF_FFFF, 31'h0001_0000, 8'd64);
    // long receiver hold-off while words keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(100);
    join
    wait_drained();
    set_range(32'h8000_0000, 32'h8000_1000, 31'h7FFF_FFFF, 8'd101);
    random_phase(150);
    wait_drained();
    set_range($urandom(), $urandom(), 31'($urandom_range(200000)), 8'($urandom_range(11, 128)));
    random_phase(150);
    wait_drained();

    $display("covered %0d adds, %0d queries (%0d answered), %0d clears",
             sb.n_add, sb.n_query, sb.n_ok_query, sb.n_clear);
    $display("checked %0d result words across ten register settings", sb.checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d words still expected", sb.mismatches, sb.pending());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
